>>> src/cpic_pkg.sv
// ----------------------------------------------------------------------------
// cpic_pkg
// Shared types and constants of the climate panel input controller.
// ----------------------------------------------------------------------------
package cpic_pkg;

	// Field widths
	localparam int KEY_W      = 8;
	localparam int KEY_IDX_W  = 3;
	localparam int TRACK_W    = 4;
	localparam int QUAD_W     = 2;
	localparam int TIME_W     = 32;
	localparam int LONG_W     = 16;
	localparam int FAN_W      = 4;
	localparam int TEMP_W     = 7;
	localparam int DIGIT_W    = 4;
	localparam int FLAG_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Default key count
	localparam int KEY_COUNT_DEF = 8;

	// Tracked key value when nothing is held
	localparam logic [TRACK_W-1:0] NO_KEY = 4'd8;

	// Key indexes; the spare key has no action
	localparam logic [KEY_IDX_W-1:0] KEY_AUTO   = 3'd0;
	localparam logic [KEY_IDX_W-1:0] KEY_AC     = 3'd2;
	localparam logic [KEY_IDX_W-1:0] KEY_FRONT  = 3'd3;
	localparam logic [KEY_IDX_W-1:0] KEY_REAR   = 3'd4;
	localparam logic [KEY_IDX_W-1:0] KEY_RECIRC = 3'd5;
	localparam logic [KEY_IDX_W-1:0] KEY_OFF    = 3'd6;
	localparam logic [KEY_IDX_W-1:0] KEY_SPARE  = 3'd7;

	// Reset values
	localparam logic [LONG_W-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [FAN_W-1:0]  FAN_LIMIT_RST  = 4'd7;
	localparam logic [TEMP_W-1:0] TEMP_FLOOR_RST = 7'd60;
	localparam logic [TEMP_W-1:0] TEMP_CEIL_RST  = 7'd85;
	localparam logic [TEMP_W-1:0] SETPOINT_RST   = 7'd72;

	// Mode flag bit positions
	localparam int FLAG_AUTO   = 0;
	localparam int FLAG_COOL   = 1;
	localparam int FLAG_FRONT  = 2;
	localparam int FLAG_REAR   = 3;
	localparam int FLAG_RECIRC = 4;
	localparam int FLAG_SCREEN = 5;

	localparam logic [FLAG_W-1:0] FLAGS_RST = 6'b100000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LONG_PRESS = 2'd0,
		CFG_FAN_LIMIT  = 2'd1,
		CFG_TEMP_FLOOR = 2'd2,
		CFG_TEMP_CEIL  = 2'd3
	} cfg_idx_t;

	// Key press event kind
	typedef enum logic [1:0] {
		PK_NONE  = 2'd0,
		PK_SHORT = 2'd1,
		PK_LONG  = 2'd2
	} press_kind_t;

	// Key tracking state
	typedef struct packed {
		logic [TRACK_W-1:0] tracked;
		logic [TIME_W-1:0]  start;
		logic               long_rep;
	} key_state_t;

	// Key event of one tick
	typedef struct packed {
		press_kind_t          kind;
		logic [KEY_IDX_W-1:0] key;
	} key_event_t;

	// Decoded encoder step
	typedef struct packed {
		logic up;
		logic dn;
	} quad_step_t;

endpackage

>>> src/cpic_if.sv
// ----------------------------------------------------------------------------
// cpic channels
// Valid/ready channels for scan ticks and panel status words.
// ----------------------------------------------------------------------------
interface cpic_in_if;
	import cpic_pkg::*;

	logic                valid;
	logic                ready;
	logic [KEY_W-1:0]    key_bits;
	logic [QUAD_W-1:0]   fan_quad;
	logic [QUAD_W-1:0]   temp_quad;
	logic [TIME_W-1:0]   now_ms;

	modport source (output valid, key_bits, fan_quad, temp_quad, now_ms, input ready);
	modport sink   (input valid, key_bits, fan_quad, temp_quad, now_ms, output ready);
endinterface

interface cpic_out_if;
	import cpic_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [FAN_W-1:0]     fan_level;
	logic [DIGIT_W-1:0]   temp_tens;
	logic [DIGIT_W-1:0]   temp_ones;
	logic                 auto_on;
	logic                 cooling_on;
	logic                 front_defog;
	logic                 rear_defog;
	logic                 recirc_on;
	logic                 screen_on;
	logic [1:0]           press_kind;
	logic [KEY_IDX_W-1:0] press_key;

	modport source (output valid, fan_level, temp_tens, temp_ones, auto_on, cooling_on,
		front_defog, rear_defog, recirc_on, screen_on, press_kind, press_key,
		input ready);
	modport sink   (input valid, fan_level, temp_tens, temp_ones, auto_on, cooling_on,
		front_defog, rear_defog, recirc_on, screen_on, press_kind, press_key,
		output ready);
endinterface

>>> src/cpic_key_scan.sv
// ----------------------------------------------------------------------------
// cpic_key_scan
// Key tracking, long/short press detection and mode flag update for one tick.
// ----------------------------------------------------------------------------
module cpic_key_scan #(
	parameter int KEY_COUNT = cpic_pkg::KEY_COUNT_DEF
) (
	input  logic [cpic_pkg::KEY_W-1:0]  key_bits,
	input  logic [cpic_pkg::TIME_W-1:0] now_ms,
	input  logic [cpic_pkg::LONG_W-1:0] hold_limit_ms,
	input  cpic_pkg::key_state_t        st,
	input  logic [cpic_pkg::FLAG_W-1:0] flags,
	output cpic_pkg::key_state_t        st_nxt,
	output logic [cpic_pkg::FLAG_W-1:0] flags_nxt,
	output cpic_pkg::key_event_t        evt
);
	import cpic_pkg::*;

	// Flag effect of one key event
	function automatic logic [FLAG_W-1:0] apply_key(
		input logic [FLAG_W-1:0]    f,
		input logic [KEY_IDX_W-1:0] k,
		input logic                 is_long
	);
		logic [FLAG_W-1:0] r;
		r = f;
		case (k)
			KEY_AUTO:   if (!is_long) r[FLAG_AUTO] = ~f[FLAG_AUTO];
			KEY_AC:     r[FLAG_COOL]   = ~f[FLAG_COOL];
			KEY_FRONT:  r[FLAG_FRONT]  = ~f[FLAG_FRONT];
			KEY_REAR:   r[FLAG_REAR]   = ~f[FLAG_REAR];
			KEY_RECIRC: r[FLAG_RECIRC] = ~f[FLAG_RECIRC];
			KEY_OFF:    if (!is_long) r[FLAG_SCREEN] = 1'b0;
			default:    r = f;
		endcase
		return r;
	endfunction

	logic [KEY_W-1:0]     keys;
	logic [KEY_IDX_W-1:0] lo_idx;
	logic [KEY_IDX_W-1:0] hi_idx;
	logic [TIME_W-1:0]    held;
	logic                 any_key;
	logic                 long_due;

	// Only the populated keys count
	always_comb begin
		for (int i = 0; i < KEY_W; i++) begin
			keys[i] = (i < KEY_COUNT) ? key_bits[i] : 1'b0;
		end
	end

	// Lowest and highest held key
	always_comb begin
		lo_idx = '0;
		hi_idx = '0;
		for (int i = KEY_W - 1; i >= 0; i--) begin
			if (keys[i]) lo_idx = KEY_IDX_W'(i);
		end
		for (int i = 0; i < KEY_W; i++) begin
			if (keys[i]) hi_idx = KEY_IDX_W'(i);
		end
	end

	assign any_key  = |keys;
	assign held     = now_ms - st.start;
	assign long_due = !st.long_rep && (held > {{(TIME_W-LONG_W){1'b0}}, hold_limit_ms});

	// Tracking and events. The lowest held key is checked first; any other
	// held key then takes tracking, ending with the highest one.
	always_comb begin
		st_nxt    = st;
		flags_nxt = flags;
		evt.kind  = PK_NONE;
		evt.key   = '0;
		if (any_key) begin
			if ({1'b0, lo_idx} == st.tracked) begin
				if (long_due) begin
					evt.kind        = PK_LONG;
					evt.key         = lo_idx;
					flags_nxt       = apply_key(flags, lo_idx, 1'b1);
					st_nxt.long_rep = 1'b1;
				end
				if (hi_idx != lo_idx) begin
					st_nxt.tracked  = {1'b0, hi_idx};
					st_nxt.start    = now_ms;
					st_nxt.long_rep = 1'b0;
				end
			end else begin
				st_nxt.tracked  = {1'b0, hi_idx};
				st_nxt.start    = now_ms;
				st_nxt.long_rep = 1'b0;
			end
		end else if (st.tracked != NO_KEY) begin
			if (!st.long_rep) begin
				evt.kind  = PK_SHORT;
				evt.key   = st.tracked[KEY_IDX_W-1:0];
				flags_nxt = apply_key(flags, st.tracked[KEY_IDX_W-1:0], 1'b0);
			end
			st_nxt.tracked  = NO_KEY;
			st_nxt.long_rep = 1'b0;
		end
	end

endmodule

>>> src/cpic_quad_dec.sv
// ----------------------------------------------------------------------------
// cpic_quad_dec
// Quadrature phase decoder: forward along 0-1-3-2, any other change reverse.
// ----------------------------------------------------------------------------
module cpic_quad_dec (
	input  logic [cpic_pkg::QUAD_W-1:0] prev,
	input  logic [cpic_pkg::QUAD_W-1:0] cur,
	output cpic_pkg::quad_step_t        step
);
	import cpic_pkg::*;

	logic moved;
	logic fwd;

	assign moved = (cur != prev);

	// Forward transitions of the Gray sequence
	always_comb begin
		case ({prev, cur})
			4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: fwd = 1'b1;
			default:                                fwd = 1'b0;
		endcase
	end

	assign step.up = moved && fwd;
	assign step.dn = moved && !fwd;

endmodule

>>> src/climate_panel_input_controller.sv
// ----------------------------------------------------------------------------
// climate_panel_input_controller
// Scan tick processing for a climate control panel: key presses toggle mode
// flags, two quadrature encoders step fan speed and temperature setpoint.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake   | word
//  ---------+-----+-------------+-----------------------------------------
//  in_ch    | in  | valid/ready | key_bits, fan_quad, temp_quad, now_ms
//  out_ch   | out | valid/ready | fan, setpoint digits, flags, key event
//  cfg      | in  | cfg_we      | cfg_index, cfg_data
//
//  One word per clock while the output is not stalled. A tick is latched in
//  the input register, processed and written to the output register with
//  the state once the output register is free or being taken.
//  A stalled output holds its word; the input register fills and then ready
//  drops until the output is taken.
//  arst_n clears the valid bits and sets panel state and configuration to defaults at once.
//
module climate_panel_input_controller #(
	parameter int KEY_COUNT = cpic_pkg::KEY_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cpic_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpic_pkg::CFG_DATA_W-1:0] cfg_data,
	cpic_in_if.sink                         in_ch,
	cpic_out_if.source                      out_ch
);
	import cpic_pkg::*;

	// Configuration
	logic [LONG_W-1:0] long_press_q;
	logic [FAN_W-1:0]  fan_limit_q;
	logic [TEMP_W-1:0] temp_floor_q;
	logic [TEMP_W-1:0] temp_ceil_q;

	// Input register
	logic              valid_s1;
	logic [KEY_W-1:0]  keys_s1;
	logic [QUAD_W-1:0] fan_quad_s1;
	logic [QUAD_W-1:0] temp_quad_s1;
	logic [TIME_W-1:0] now_s1;

	// Panel state
	key_state_t        key_st_q;
	logic [QUAD_W-1:0] prev_fan_q;
	logic [QUAD_W-1:0] prev_temp_q;
	logic [FAN_W-1:0]  fan_q;
	logic [TEMP_W-1:0] setpoint_q;
	logic [FLAG_W-1:0] flags_q;

	// Output register
	logic                 out_valid_q;
	logic [FAN_W-1:0]     out_fan_q;
	logic [DIGIT_W-1:0]   out_tens_q;
	logic [DIGIT_W-1:0]   out_ones_q;
	logic [FLAG_W-1:0]    out_flags_q;
	key_event_t           out_evt_q;

	logic              advance;
	key_state_t        key_st_nxt;
	logic [FLAG_W-1:0] flags_nxt;
	key_event_t        evt;
	quad_step_t        fan_step;
	quad_step_t        temp_step;
	logic [FAN_W-1:0]  fan_nxt;
	logic [TEMP_W-1:0] setpoint_nxt;
	logic [14:0]       tens_prod;
	logic [DIGIT_W-1:0] tens;
	logic [DIGIT_W-1:0] ones;

	// Handshake
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= LONG_PRESS_RST;
			fan_limit_q  <= FAN_LIMIT_RST;
			temp_floor_q <= TEMP_FLOOR_RST;
			temp_ceil_q  <= TEMP_CEIL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LONG_PRESS: long_press_q <= cfg_data[LONG_W-1:0];
				CFG_FAN_LIMIT:  fan_limit_q  <= cfg_data[FAN_W-1:0];
				CFG_TEMP_FLOOR: temp_floor_q <= cfg_data[TEMP_W-1:0];
				CFG_TEMP_CEIL:  temp_ceil_q  <= cfg_data[TEMP_W-1:0];
				default:        long_press_q <= long_press_q;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			keys_s1      <= in_ch.key_bits;
			fan_quad_s1  <= in_ch.fan_quad;
			temp_quad_s1 <= in_ch.temp_quad;
			now_s1       <= in_ch.now_ms;
		end
	end

	// Key handling
	cpic_key_scan #(
		.KEY_COUNT(KEY_COUNT)
	) u_key_scan (
		.key_bits      (keys_s1),
		.now_ms        (now_s1),
		.hold_limit_ms (long_press_q),
		.st            (key_st_q),
		.flags         (flags_q),
		.st_nxt        (key_st_nxt),
		.flags_nxt     (flags_nxt),
		.evt           (evt)
	);

	// Encoders
	cpic_quad_dec u_fan_dec (
		.prev (prev_fan_q),
		.cur  (fan_quad_s1),
		.step (fan_step)
	);

	cpic_quad_dec u_temp_dec (
		.prev (prev_temp_q),
		.cur  (temp_quad_s1),
		.step (temp_step)
	);

	// Clamped fan and setpoint steps
	always_comb begin
		fan_nxt = fan_q;
		if (fan_step.up && (fan_q < fan_limit_q)) begin
			fan_nxt = fan_q + FAN_W'(1);
		end else if (fan_step.dn && (fan_q != '0)) begin
			fan_nxt = fan_q - FAN_W'(1);
		end
		setpoint_nxt = setpoint_q;
		if (temp_step.up && (setpoint_q < temp_ceil_q)) begin
			setpoint_nxt = setpoint_q + TEMP_W'(1);
		end else if (temp_step.dn && (setpoint_q > temp_floor_q)) begin
			setpoint_nxt = setpoint_q - TEMP_W'(1);
		end
	end

	// Decimal digits: x/10 as (x*205)>>11, exact for 7-bit values
	assign tens_prod = 15'(setpoint_nxt) * 15'd205;
	assign tens      = tens_prod[14:11];
	assign ones      = DIGIT_W'(setpoint_nxt - TEMP_W'(tens) * TEMP_W'(10));

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_st_q    <= '{tracked: NO_KEY, start: '0, long_rep: 1'b0};
			prev_fan_q  <= '0;
			prev_temp_q <= '0;
			fan_q       <= '0;
			setpoint_q  <= SETPOINT_RST;
			flags_q     <= FLAGS_RST;
		end else if (advance) begin
			key_st_q    <= key_st_nxt;
			prev_fan_q  <= fan_quad_s1;
			prev_temp_q <= temp_quad_s1;
			fan_q       <= fan_nxt;
			setpoint_q  <= setpoint_nxt;
			flags_q     <= flags_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_fan_q   <= fan_nxt;
			out_tens_q  <= tens;
			out_ones_q  <= ones;
			out_flags_q <= flags_nxt;
			out_evt_q   <= evt;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.fan_level   = out_fan_q;
	assign out_ch.temp_tens   = out_tens_q;
	assign out_ch.temp_ones   = out_ones_q;
	assign out_ch.auto_on     = out_flags_q[FLAG_AUTO];
	assign out_ch.cooling_on  = out_flags_q[FLAG_COOL];
	assign out_ch.front_defog = out_flags_q[FLAG_FRONT];
	assign out_ch.rear_defog  = out_flags_q[FLAG_REAR];
	assign out_ch.recirc_on   = out_flags_q[FLAG_RECIRC];
	assign out_ch.screen_on   = out_flags_q[FLAG_SCREEN];
	assign out_ch.press_kind  = out_evt_q.kind;
	assign out_ch.press_key   = out_evt_q.key;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: climate panel input controller testbench
// Feeds scan ticks over the valid/ready input channel and checks every status
// word against an in-bench model of key tracking, press timing and encoder
// steps. A short table of directed ticks runs first, then random key holds,
// encoder turns and timestamps under several register settings, with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cpic_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_WAIT  = 4;
	localparam int PHASES      = 8;
	localparam int PHASE_TICKS = 110;

	typedef struct packed {
		logic [FAN_W-1:0]     fan_level;
		logic [DIGIT_W-1:0]   temp_tens;
		logic [DIGIT_W-1:0]   temp_ones;
		logic                 auto_on;
		logic                 cooling_on;
		logic                 front_defog;
		logic                 rear_defog;
		logic                 recirc_on;
		logic                 screen_on;
		press_kind_t          press_kind;
		logic [KEY_IDX_W-1:0] press_key;
	} panel_word_t;

	typedef struct packed {
		logic [KEY_W-1:0]  keys;
		logic [QUAD_W-1:0] fq;
		logic [QUAD_W-1:0] tq;
		logic [TIME_W-1:0] now;
		logic              known;
		panel_word_t       want;
	} scan_row_t;

	typedef struct packed {
		logic [LONG_W-1:0] lp;
		logic [FAN_W-1:0]  fl;
		logic [TEMP_W-1:0] lo;
		logic [TEMP_W-1:0] hi;
	} reg_set_t;

	// Word right after reset with no input activity
	localparam panel_word_t IDLE_WORD =
		'{4'd0, 4'd7, 4'd2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PK_NONE, 3'd0};

	// Directed ticks; rows with known set carry their expected word
	scan_row_t dir_tab [26] = '{
		'{8'h00, 2'd0, 2'd0, 32'd0, 1'b1, IDLE_WORD},
		'{8'(1 << KEY_AUTO), 2'd0, 2'd0, 32'd10, 1'b1, IDLE_WORD},
		'{8'h00, 2'd0, 2'd0, 32'd20, 1'b1,
			'{4'd0, 4'd7, 4'd2, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PK_SHORT, 3'(KEY_AUTO)}},
		'{8'(1 << KEY_SPARE), 2'd0, 2'd0, 32'd100, 1'b0, IDLE_WORD},
		'{8'(1 << KEY_SPARE), 2'd0, 2'd0, 32'd1101, 1'b1,
			'{4'd0, 4'd7, 4'd2, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PK_LONG, 3'(KEY_SPARE)}},
		'{8'(1 << KEY_SPARE), 2'd0, 2'd0, 32'd5000, 1'b0, IDLE_WORD},
		'{8'h00, 2'd0, 2'd0, 32'd5010, 1'b0, IDLE_WORD},
		// fan encoder: four forward steps, then three reverse ones
		'{8'h00, 2'd1, 2'd0, 32'd5020, 1'b0, IDLE_WORD},
		'{8'h00, 2'd3, 2'd0, 32'd5030, 1'b0, IDLE_WORD},
		'{8'h00, 2'd2, 2'd0, 32'd5040, 1'b0, IDLE_WORD},
		'{8'h00, 2'd0, 2'd0, 32'd5050, 1'b0, IDLE_WORD},
		'{8'h00, 2'd2, 2'd0, 32'd5060, 1'b0, IDLE_WORD},
		'{8'h00, 2'd3, 2'd0, 32'd5070, 1'b0, IDLE_WORD},
		'{8'h00, 2'd0, 2'd0, 32'd5080, 1'b0, IDLE_WORD},
		// temperature encoder, the last change is a diagonal jump
		'{8'h00, 2'd0, 2'd1, 32'd5090, 1'b0, IDLE_WORD},
		'{8'h00, 2'd0, 2'd3, 32'd5100, 1'b0, IDLE_WORD},
		'{8'h00, 2'd0, 2'd0, 32'd5110, 1'b0, IDLE_WORD},
		// two keys held: tracking restarts on the higher key each tick, no long event
		'{8'(1 << KEY_AC) | 8'(1 << KEY_FRONT), 2'd0, 2'd0, 32'd6000, 1'b0, IDLE_WORD},
		'{8'(1 << KEY_AC) | 8'(1 << KEY_FRONT), 2'd0, 2'd0, 32'd9000, 1'b0, IDLE_WORD},
		'{8'h00, 2'd0, 2'd0, 32'd9010, 1'b0, IDLE_WORD},
		'{8'(1 << KEY_OFF), 2'd0, 2'd0, 32'd9100, 1'b0, IDLE_WORD},
		'{8'h00, 2'd0, 2'd0, 32'd9110, 1'b0, IDLE_WORD},
		// held time across the 32-bit wrap
		'{8'(1 << KEY_AC), 2'd0, 2'd0, 32'hFFFF_FF00, 1'b0, IDLE_WORD},
		'{8'(1 << KEY_AC), 2'd0, 2'd0, 32'h0000_0300, 1'b0, IDLE_WORD},
		'{8'hFF, 2'd0, 2'd0, 32'hFFFF_FFFF, 1'b0, IDLE_WORD},
		'{8'h00, 2'd0, 2'd0, 32'h0000_0010, 1'b0, IDLE_WORD}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cpic_in_if  in_ch();
	cpic_out_if out_ch();

	climate_panel_input_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// Model registers and state
	logic [LONG_W-1:0]  lp_ms;
	logic [FAN_W-1:0]   fan_max;
	logic [TEMP_W-1:0]  temp_lo;
	logic [TEMP_W-1:0]  temp_hi;
	logic [TRACK_W-1:0] trk_key;
	logic [TIME_W-1:0]  trk_start;
	logic               trk_long;
	logic [QUAD_W-1:0]  fan_q;
	logic [QUAD_W-1:0]  temp_q;
	logic [FAN_W-1:0]   fan_lvl;
	logic [TEMP_W-1:0]  setp;
	logic [FLAG_W-1:0]  modes;

	panel_word_t status_q [$];

	// Stimulus generator state
	logic [KEY_W-1:0]  held;
	int                hold_left;
	logic [QUAD_W-1:0] fan_tx;
	logic [QUAD_W-1:0] temp_tx;
	bit                fan_up;
	bit                temp_up;
	logic [TIME_W-1:0] t_now;
	int                base_ms;

	bit calm;
	bit hold_req;
	int fail_cnt;
	int n_ticks;
	int n_short;
	int n_long;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Encoder phase one step forward (0,1,3,2) or back
	function automatic logic [QUAD_W-1:0] quad_turn(logic [QUAD_W-1:0] q, bit up);
		case (q)
			2'd0: return up ? 2'd1 : 2'd2;
			2'd1: return up ? 2'd3 : 2'd0;
			2'd3: return up ? 2'd2 : 2'd1;
			default: return up ? 2'd0 : 2'd3;
		endcase
	endfunction

	// Flag action of a short or long press
	function automatic void key_action(logic [KEY_IDX_W-1:0] k, bit is_long);
		case (k)
			KEY_AUTO:   if (!is_long) modes[FLAG_AUTO] = ~modes[FLAG_AUTO];
			KEY_AC:     modes[FLAG_COOL] = ~modes[FLAG_COOL];
			KEY_FRONT:  modes[FLAG_FRONT] = ~modes[FLAG_FRONT];
			KEY_REAR:   modes[FLAG_REAR] = ~modes[FLAG_REAR];
			KEY_RECIRC: modes[FLAG_RECIRC] = ~modes[FLAG_RECIRC];
			KEY_OFF:    if (!is_long) modes[FLAG_SCREEN] = 1'b0;
			default: ;
		endcase
	endfunction

	// Panel state after one scan tick
	function automatic panel_word_t panel_next(logic [KEY_W-1:0] keys,
		logic [QUAD_W-1:0] fq, logic [QUAD_W-1:0] tq, logic [TIME_W-1:0] now);
		panel_word_t w;
		press_kind_t kind;
		logic [KEY_IDX_W-1:0] ek;
		logic [TIME_W-1:0] held_ms;
		int i;
		kind = PK_NONE;
		ek = '0;
		// key scan in index order, last differing key takes over
		for (i = 0; i < KEY_W; i++) begin
			if (keys[i]) begin
				held_ms = now - trk_start;
				if (trk_key != TRACK_W'(i)) begin
					trk_key = TRACK_W'(i);
					trk_start = now;
					trk_long = 1'b0;
				end else if (!trk_long && held_ms > {16'd0, lp_ms}) begin
					kind = PK_LONG;
					ek = KEY_IDX_W'(i);
					key_action(ek, 1'b1);
					trk_long = 1'b1;
				end
			end
		end
		// release: short event unless a long one was given
		if (keys == '0 && trk_key != NO_KEY) begin
			if (!trk_long) begin
				kind = PK_SHORT;
				ek = trk_key[KEY_IDX_W-1:0];
				key_action(ek, 1'b0);
			end
			trk_key = NO_KEY;
			trk_long = 1'b0;
		end
		// encoders: forward step up, any other change steps down
		if (fq != fan_q) begin
			if (fq == quad_turn(fan_q, 1'b1)) begin
				if (fan_lvl < fan_max) fan_lvl++;
			end else if (fan_lvl > 0) begin
				fan_lvl--;
			end
			fan_q = fq;
		end
		if (tq != temp_q) begin
			if (tq == quad_turn(temp_q, 1'b1)) begin
				if (setp < temp_hi) setp++;
			end else if (setp > temp_lo) begin
				setp--;
			end
			temp_q = tq;
		end
		w.fan_level   = fan_lvl;
		w.temp_tens   = DIGIT_W'(setp / 7'd10);
		w.temp_ones   = DIGIT_W'(setp % 7'd10);
		w.auto_on     = modes[FLAG_AUTO];
		w.cooling_on  = modes[FLAG_COOL];
		w.front_defog = modes[FLAG_FRONT];
		w.rear_defog  = modes[FLAG_REAR];
		w.recirc_on   = modes[FLAG_RECIRC];
		w.screen_on   = modes[FLAG_SCREEN];
		w.press_kind  = kind;
		w.press_key   = (kind != PK_NONE) ? ek : '0;
		return w;
	endfunction

	// Gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Encoder phase: hold, turn with the current bias, turn against it, or jump
	function automatic logic [QUAD_W-1:0] enc_move(logic [QUAD_W-1:0] q, bit up);
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return q;
		if (r < 8) return quad_turn(q, up);
		if (r == 8) return quad_turn(q, !up);
		return QUAD_W'($urandom_range(0, 3));
	endfunction

	// Random tick: key holds of random length, mostly released cleanly
	task automatic next_tick(output logic [KEY_W-1:0] k, output logic [QUAD_W-1:0] f,
		output logic [QUAD_W-1:0] t, output logic [TIME_W-1:0] n);
		int r;
		if (hold_left > 0) begin
			hold_left--;
			k = held;
		end else if (held != '0 && $urandom_range(0, 4) != 0) begin
			held = '0;
			k = '0;
		end else begin
			r = $urandom_range(0, 9);
			if (r < 7)
				held = KEY_W'(1 << $urandom_range(0, 7));
			else if (r == 7)
				held = '0;
			else if (r == 8)
				held = KEY_W'(1 << $urandom_range(0, 7)) | KEY_W'(1 << $urandom_range(0, 7));
			else
				held = KEY_W'($urandom_range(0, 255));
			hold_left = $urandom_range(0, 10);
			k = held;
		end
		if ($urandom_range(0, 24) == 0) fan_up = !fan_up;
		if ($urandom_range(0, 24) == 0) temp_up = !temp_up;
		fan_tx = enc_move(fan_tx, fan_up);
		temp_tx = enc_move(temp_tx, temp_up);
		f = fan_tx;
		t = temp_tx;
		if ($urandom_range(0, 49) == 0)
			t_now = $urandom();
		else
			t_now += $urandom_range(0, 2 * base_ms);
		n = t_now;
	endtask

	// Offer one tick; a negative gap waits for all status words first
	task automatic send_tick(input logic [KEY_W-1:0] k, input logic [QUAD_W-1:0] f,
		input logic [QUAD_W-1:0] t, input logic [TIME_W-1:0] n, input int gap,
		input bit known, input panel_word_t fixed_w);
		panel_word_t pred;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			if (gap < 0) begin
				do @(posedge clk); while (status_q.size() != 0);
			end else begin
				repeat (gap) @(posedge clk);
			end
		end
		in_ch.valid     <= 1'b1;
		in_ch.key_bits  <= k;
		in_ch.fan_quad  <= f;
		in_ch.temp_quad <= t;
		in_ch.now_ms    <= n;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		n_ticks++;
		pred = panel_next(k, f, t, n);
		status_q.push_back(known ? fixed_w : pred);
	endtask

	// Drop valid, wait for every status word, then let the pipeline empty
	task automatic settle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (status_q.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Write all four registers on back-to-back cycles
	task automatic load_regs(input reg_set_t s);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LONG_PRESS;
		cfg_data  <= s.lp;
		@(posedge clk);
		lp_ms = s.lp;
		cfg_index <= CFG_FAN_LIMIT;
		cfg_data  <= CFG_DATA_W'(s.fl);
		@(posedge clk);
		fan_max = s.fl;
		cfg_index <= CFG_TEMP_FLOOR;
		cfg_data  <= CFG_DATA_W'(s.lo);
		@(posedge clk);
		temp_lo = s.lo;
		cfg_index <= CFG_TEMP_CEIL;
		cfg_data  <= CFG_DATA_W'(s.hi);
		@(posedge clk);
		temp_hi = s.hi;
		cfg_we <= 1'b0;
	endtask

	task automatic cmp_field(input string nm, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", nm, want, got);
			fail_cnt++;
		end
	endtask

	// Status word check against the oldest expectation
	always @(posedge clk) begin : check_status
		panel_word_t want;
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (status_q.size() == 0) begin
				$error("status word arrived with nothing expected");
				fail_cnt++;
			end else begin
				want = status_q.pop_front();
				cmp_field("fan_level", want.fan_level, out_ch.fan_level);
				cmp_field("temp_tens", want.temp_tens, out_ch.temp_tens);
				cmp_field("temp_ones", want.temp_ones, out_ch.temp_ones);
				cmp_field("auto_on", want.auto_on, out_ch.auto_on);
				cmp_field("cooling_on", want.cooling_on, out_ch.cooling_on);
				cmp_field("front_defog", want.front_defog, out_ch.front_defog);
				cmp_field("rear_defog", want.rear_defog, out_ch.rear_defog);
				cmp_field("recirc_on", want.recirc_on, out_ch.recirc_on);
				cmp_field("screen_on", want.screen_on, out_ch.screen_on);
				cmp_field("press_kind", want.press_kind, out_ch.press_kind);
				cmp_field("press_key", want.press_key, out_ch.press_key);
				if (want.press_kind == PK_SHORT) n_short++;
				if (want.press_kind == PK_LONG) n_long++;
			end
		end
	end

	// Receiver: random stalls, one long hold-off on request
	initial begin : status_sink
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (calm) begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					out_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Watchdog on cycles with no word moving on either channel
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				idle = 0;
			else
				idle++;
		end
		$display("FAIL climate_panel_input_controller");
		$finish;
	end

	// Main sequence
	initial begin : main_seq
		reg_set_t sets [PHASES];
		logic [KEY_W-1:0]  k;
		logic [QUAD_W-1:0] f;
		logic [QUAD_W-1:0] t;
		logic [TIME_W-1:0] n;
		int p;
		int i;
		int gap;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_LONG_PRESS;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.key_bits  = '0;
		in_ch.fan_quad  = '0;
		in_ch.temp_quad = '0;
		in_ch.now_ms    = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		fail_cnt = 0;
		n_ticks = 0;
		n_short = 0;
		n_long = 0;

		lp_ms = LONG_PRESS_RST;
		fan_max = FAN_LIMIT_RST;
		temp_lo = TEMP_FLOOR_RST;
		temp_hi = TEMP_CEIL_RST;
		trk_key = NO_KEY;
		trk_start = '0;
		trk_long = 1'b0;
		fan_q = '0;
		temp_q = '0;
		fan_lvl = '0;
		setp = SETPOINT_RST;
		modes = FLAGS_RST;

		held = '0;
		hold_left = 0;
		fan_tx = '0;
		temp_tx = '0;
		fan_up = 1'b1;
		temp_up = 1'b1;
		t_now = 32'h0000_0010;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ticks at reset settings
		for (i = 0; i < $size(dir_tab); i++)
			send_tick(dir_tab[i].keys, dir_tab[i].fq, dir_tab[i].tq, dir_tab[i].now,
				pick_gap(), dir_tab[i].known, dir_tab[i].want);

		// register settings: extremes, a narrow range and the reset values first, then random ones
		sets[0] = '{16'd1, 4'd1, 7'd0, 7'd99};
		sets[1] = '{16'd65535, 4'd15, 7'd99, 7'd99};
		sets[2] = '{16'd50, 4'd0, 7'd127, 7'd127};
		sets[3] = '{16'd200, 4'd8, 7'd40, 7'd60};
		sets[4] = '{LONG_PRESS_RST, FAN_LIMIT_RST, TEMP_FLOOR_RST, TEMP_CEIL_RST};
		for (p = 5; p < PHASES; p++)
			sets[p] = '{16'($urandom_range(1, 3000)), 4'($urandom_range(1, 15)),
				7'($urandom_range(0, 99)), 7'($urandom_range(0, 99))};

		for (p = 0; p < PHASES; p++) begin
			settle();
			load_regs(sets[p]);
			base_ms = int'(sets[p].lp) / 8 + 1;
			calm = (p == 2);
			if (p == 4) t_now = 32'hFFFF_FFFF - 32'($urandom_range(0, 5000));
			for (i = 0; i < PHASE_TICKS; i++) begin
				// long receiver hold-off, then a full drain by the sender
				if (p == 3 && i == 40) hold_req = 1'b1;
				gap = (p == 3 && i == 90) ? -1 : pick_gap();
				next_tick(k, f, t, n);
				send_tick(k, f, t, n, gap, 1'b0, IDLE_WORD);
			end
		end
		calm = 1'b0;

		settle();
		repeat (8) @(posedge clk);
		$display("Ran %0d scan ticks over %0d register settings plus reset defaults.",
			n_ticks, PHASES);
		$display("Saw %0d short and %0d long key events; %0d mismatches.",
			n_short, n_long, fail_cnt);
		if (fail_cnt == 0)
			$display("PASS climate_panel_input_controller");
		else
			$display("FAIL climate_panel_input_controller");
		$finish;
	end

endmodule
